### sv/tcphop_pkg.sv
// Shared types and constants for the TCP header and option parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcphop_pkg;

   // Parse phase codes
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_KIND = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   // Record kinds on the result channel
   localparam logic [3:0] REC_HEADER    = 4'd0;
   localparam logic [3:0] REC_END       = 4'd1;
   localparam logic [3:0] REC_NOP       = 4'd2;
   localparam logic [3:0] REC_MSS       = 4'd3;
   localparam logic [3:0] REC_WSCALE    = 4'd4;
   localparam logic [3:0] REC_SACKOK    = 4'd5;
   localparam logic [3:0] REC_SACK_WORD = 4'd6;
   localparam logic [3:0] REC_ECHO      = 4'd7;
   localparam logic [3:0] REC_ECHOREPLY = 4'd8;
   localparam logic [3:0] REC_TIMESTAMP = 4'd9;
   localparam logic [3:0] REC_UNKNOWN   = 4'd10;
   localparam logic [3:0] REC_ERROR     = 4'd11;

   // TCP option kinds
   localparam logic [7:0] OPT_MSS       = 8'd2;
   localparam logic [7:0] OPT_WSCALE    = 8'd3;
   localparam logic [7:0] OPT_SACKOK    = 8'd4;
   localparam logic [7:0] OPT_SACK      = 8'd5;
   localparam logic [7:0] OPT_ECHO      = 8'd6;
   localparam logic [7:0] OPT_ECHOREPLY = 8'd7;
   localparam logic [7:0] OPT_TIMESTAMP = 8'd8;
   localparam logic [7:0] OPT_FIRST_UNK = 8'd9;

   localparam logic [5:0] HDR_BYTES   = 6'd20;
   localparam logic [3:0] MIN_OFFSET  = 4'd5;
   localparam int         RSP_DATA_W  = 224;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [31:0] sequence_number;
      logic [31:0] ack_number;
      logic [3:0]  data_offset;
      logic [7:0]  flag_bits;
      logic [15:0] window_size;
      logic [15:0] checksum_field;
      logic [15:0] urgent_pointer;
      logic [31:0] option_value_a;
      logic [31:0] option_value_b;
   } rec_type;

   // Legal option length for a given kind
   function automatic logic length_ok(input logic [7:0] kind, input logic [7:0] len);
      logic ok;
      unique case (kind)
         OPT_MSS:                  ok = (len == 8'd4);
         OPT_WSCALE:               ok = (len == 8'd3);
         OPT_SACKOK:               ok = (len == 8'd2);
         OPT_SACK:                 ok = (len >= 8'd2) && (len[1:0] == 2'b10);
         OPT_ECHO, OPT_ECHOREPLY:  ok = (len == 8'd6);
         OPT_TIMESTAMP:            ok = (len == 8'd10);
         default:                  ok = (len >= 8'd2);
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

### sv/tcphop_parse.sv
// Byte-wise parse engine: header capture, option walk and record build.
// Depends on tcphop_pkg.
`default_nettype none

module tcphop_parse
   import tcphop_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       beat_valid,
   input  wire logic [7:0] data_byte,
   input  wire logic       first_byte,
   output logic            rec_valid,
   output rec_type         rec
);

   logic [2:0]   phase_ff, phase_in;
   logic [5:0]   bp_ff, bp_in;
   logic [5:0]   end_ff, end_in;
   logic [7:0]   kind_ff, kind_in;
   logic [7:0]   len_ff, len_in;
   logic [7:0]   idx_ff, idx_in;
   logic [159:0] hdr_ff, hdr_in;
   logic [31:0]  acc_ff, acc_in;
   logic [31:0]  hold_ff, hold_in;

   logic [2:0]   cur_phase;
   logic [5:0]   cur_bp, bp_inc;
   logic [159:0] hdr_shift;
   logic [31:0]  acc_shift;
   logic [7:0]   idx_inc, len_minus;
   logic [8:0]   reach;
   logic [3:0]   off;
   logic [5:0]   new_end;

   // Next state and record for one beat
   always_comb begin
      phase_in = phase_ff;
      bp_in    = bp_ff;
      end_in   = end_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      hdr_in   = hdr_ff;
      acc_in   = acc_ff;
      hold_in  = hold_ff;
      rec_valid = 1'b0;
      rec       = '0;

      // a first byte restarts the parse
      cur_phase = first_byte ? PH_HDR : phase_ff;
      cur_bp    = first_byte ? 6'd0 : bp_ff;
      bp_inc    = cur_bp + 6'd1;
      hdr_shift = {hdr_ff[151:0], data_byte};
      acc_shift = {acc_ff[23:0], data_byte};
      idx_inc   = idx_ff + 8'd1;
      len_minus = len_ff - 8'd2;
      reach     = {3'b000, cur_bp} - 9'd1 + {1'b0, data_byte};
      off       = hdr_shift[63:60];
      new_end   = {off, 2'b00};

      if (first_byte) begin
         phase_in = PH_HDR;
         end_in   = '0;
         kind_in  = '0;
         len_in   = '0;
         idx_in   = '0;
      end

      unique case (cur_phase)
         PH_HDR: begin
            hdr_in = hdr_shift;
            bp_in  = bp_inc;
            if (bp_inc == HDR_BYTES) begin
               rec_valid = 1'b1;
               if (off < MIN_OFFSET) begin
                  rec.record_kind = REC_ERROR;
                  phase_in = PH_DONE;
               end else begin
                  end_in = new_end;
                  rec.record_kind      = REC_HEADER;
                  rec.source_port      = hdr_shift[159:144];
                  rec.destination_port = hdr_shift[143:128];
                  rec.sequence_number  = hdr_shift[127:96];
                  rec.ack_number       = hdr_shift[95:64];
                  rec.data_offset      = off;
                  rec.flag_bits        = hdr_shift[55:48];
                  rec.window_size      = hdr_shift[47:32];
                  rec.checksum_field   = hdr_shift[31:16];
                  rec.urgent_pointer   = hdr_shift[15:0];
                  phase_in = (bp_inc >= new_end) ? PH_DONE : PH_KIND;
               end
            end
         end

         PH_KIND: begin
            bp_in = bp_inc;
            if (data_byte <= 8'd1) begin
               // end of list or no-op: single-byte options
               rec_valid = 1'b1;
               rec.record_kind = data_byte[3:0] + 4'd1;
               phase_in = (bp_inc >= end_ff) ? PH_DONE : PH_KIND;
            end else if (bp_inc >= end_ff) begin
               rec_valid = 1'b1;
               rec.record_kind = REC_ERROR;
               phase_in = PH_DONE;
            end else begin
               kind_in  = data_byte;
               phase_in = PH_LEN;
            end
         end

         PH_LEN: begin
            if (!length_ok(kind_ff, data_byte) || (cur_bp == 6'd0) ||
                (reach > {3'b000, end_ff})) begin
               rec_valid = 1'b1;
               rec.record_kind = REC_ERROR;
               phase_in = PH_DONE;
            end else begin
               bp_in  = bp_inc;
               len_in = data_byte;
               idx_in = '0;
               acc_in = '0;
               if (kind_ff >= OPT_FIRST_UNK) begin
                  rec_valid = 1'b1;
                  rec.record_kind    = REC_UNKNOWN;
                  rec.option_value_a = {24'd0, kind_ff};
                  rec.option_value_b = {24'd0, data_byte};
               end
               if (data_byte == 8'd2) begin
                  phase_in = (bp_inc >= end_ff) ? PH_DONE : PH_KIND;
                  if (kind_ff == OPT_SACKOK) begin
                     rec_valid = 1'b1;
                     rec.record_kind = REC_SACKOK;
                  end
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end

         PH_BODY: begin
            bp_in  = bp_inc;
            acc_in = acc_shift;
            idx_in = idx_inc;
            unique case (kind_ff)
               OPT_MSS: begin
                  if (idx_inc == 8'd2) begin
                     rec_valid = 1'b1;
                     rec.record_kind    = REC_MSS;
                     rec.option_value_a = {16'd0, acc_shift[15:0]};
                  end
               end
               OPT_WSCALE: begin
                  if (idx_inc == 8'd1) begin
                     rec_valid = 1'b1;
                     rec.record_kind    = REC_WSCALE;
                     rec.option_value_a = {24'd0, data_byte};
                  end
               end
               OPT_SACK: begin
                  if (idx_inc[1:0] == 2'b00) begin
                     rec_valid = 1'b1;
                     rec.record_kind    = REC_SACK_WORD;
                     rec.option_value_a = acc_shift;
                  end
               end
               OPT_ECHO, OPT_ECHOREPLY: begin
                  if (idx_inc == 8'd4) begin
                     rec_valid = 1'b1;
                     rec.record_kind    = (kind_ff == OPT_ECHO) ? REC_ECHO : REC_ECHOREPLY;
                     rec.option_value_a = acc_shift;
                  end
               end
               OPT_TIMESTAMP: begin
                  if (idx_inc == 8'd4) hold_in = acc_shift;
                  if (idx_inc == 8'd8) begin
                     rec_valid = 1'b1;
                     rec.record_kind    = REC_TIMESTAMP;
                     rec.option_value_a = hold_ff;
                     rec.option_value_b = acc_shift;
                  end
               end
               default: ;
            endcase
            if ((len_ff < 8'd2) || (idx_inc >= len_minus))
               phase_in = (bp_inc >= end_ff) ? PH_DONE : PH_KIND;
         end

         default: ;  // idle, done and unused codes ignore the byte
      endcase

      if (!beat_valid) rec_valid = 1'b0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bp_ff    <= '0;
         end_ff   <= '0;
         kind_ff  <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
      end else if (beat_valid) begin
         phase_ff <= phase_in;
         bp_ff    <= bp_in;
         end_ff   <= end_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
      end
   end

   // Header and option data
   always_ff @(posedge clock) begin
      if (beat_valid) begin
         hdr_ff  <= hdr_in;
         acc_ff  <= acc_in;
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

### sv/tcphop_out.sv
// Result register: holds one record until the receiver takes it.
// Depends on tcphop_pkg.
`default_nettype none

module tcphop_out
   import tcphop_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  rec_valid,
   input  rec_type                    rec,
   output logic                       can_load,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [3:0]                 rsp_tuser
);

   logic    valid_ff, valid_in;
   rec_type rec_ff;

   // a new beat may enter when the slot is empty or drains this cycle
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      if (load)            valid_in = rec_valid;
      else if (rsp_tready) valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load && rec_valid) rec_ff <= rec;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = rec_ff.record_kind;
   assign rsp_tdata  = {4'd0,
                        rec_ff.option_value_b,
                        rec_ff.option_value_a,
                        rec_ff.urgent_pointer,
                        rec_ff.checksum_field,
                        rec_ff.window_size,
                        rec_ff.flag_bits,
                        rec_ff.data_offset,
                        rec_ff.ack_number,
                        rec_ff.sequence_number,
                        rec_ff.destination_port,
                        rec_ff.source_port};

endmodule

`default_nettype wire

### sv/tcp_header_option_parser.sv
// TCP header and option parser, top level.
// Takes a segment one byte per beat and returns header and option records.
// Input: req_tdata carries one segment byte, req_tuser marks byte 0 of a
//   header; any beat with req_tuser high restarts the parse.
// Output: one record per beat on rsp_; rsp_tuser is the record kind, rsp_tdata
//   the header fields (header record) and the two option values.
// A header record comes out with the 20th byte, then one record per option
//   (one per SACK word); a malformed header or option gives an error record
//   and later bytes are dropped until the next first byte. Bytes past the
//   option area produce nothing.
// Latency: a record is valid on rsp_ the cycle after the byte that caused it.
// Throughput: one byte per cycle unless stalled as below; the result register
//   lets the next byte in while a record is offered and rsp_tready is high.
// Stall: while a record waits with rsp_tready low, req_tready is low.
// Reset (synchronous, active high): parser idles until a first byte and the
//   result register empties.
// Depends on tcphop_pkg, tcphop_parse, tcphop_out.
`default_nettype none

module tcp_header_option_parser
   import tcphop_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] first_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] source_port, [31:16] destination_port, [63:32] sequence_number,
   // [95:64] ack_number, [99:96] data_offset, [107:100] flag_bits,
   // [123:108] window_size, [139:124] checksum_field, [155:140] urgent_pointer,
   // [187:156] option_value_a, [219:188] option_value_b, [223:220] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [3:0]                 rsp_tuser    // [3:0] record_kind
);

   logic    beat;
   logic    can_load;
   logic    rec_valid;
   rec_type rec;

   assign req_tready = can_load;
   assign beat       = req_tvalid && can_load;

   tcphop_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat),
      .data_byte  (req_tdata),
      .first_byte (req_tuser),
      .rec_valid  (rec_valid),
      .rec        (rec)
   );

   tcphop_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (beat),
      .rec_valid  (rec_valid),
      .rec        (rec),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### sim/tcphop_record_checker.sv
// Record checker for the TCP header and option parser testbench.
// Watches both stream channels, predicts each record from the accepted bytes
// and compares it with what comes out. Depends on tcphop_pkg.
`timescale 1ns / 100ps

module tcphop_record_checker
   import tcphop_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] first_byte
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] source_port ... [219:188] option_value_b, [223:220] zero
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [3:0]            rsp_tuser,   // [3:0] record_kind
   output int                         mismatches,
   output int                         pending
);

   // Parser state as predicted
   logic [5:0]  seg_pos;
   logic [31:0] hdr_word [5];
   logic [5:0]  area_end;
   logic [7:0]  cur_kind;
   logic [7:0]  cur_len;
   logic [7:0]  body_count;
   logic [31:0] body_acc;
   logic [31:0] ts_hold;
   logic [2:0]  phase;

   rec_type expected_records [$];

   initial mismatches = 0;
   initial pending = 0;

   function automatic void clear_parser();
      seg_pos    = '0;
      for (int i = 0; i < 5; i++) hdr_word[i] = '0;
      area_end   = '0;
      cur_kind   = '0;
      cur_len    = '0;
      body_count = '0;
      body_acc   = '0;
      ts_hold    = '0;
      phase      = PH_IDLE;
   endfunction

   function automatic rec_type option_rec(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
      rec_type r;
      r = '0;
      r.record_kind    = kind;
      r.option_value_a = a;
      r.option_value_b = b;
      return r;
   endfunction

   // Next kind byte, or done once the option area is used up
   function automatic void close_option();
      phase = (seg_pos >= area_end) ? PH_DONE : PH_KIND;
   endfunction

   function automatic logic legal_length(logic [7:0] kind, logic [7:0] len);
      case (kind)
         OPT_MSS:                 return len == 8'd4;
         OPT_WSCALE:              return len == 8'd3;
         OPT_SACKOK:              return len == 8'd2;
         OPT_SACK:                return (len >= 8'd2) && ((len - 8'd2) % 4 == 0);
         OPT_ECHO, OPT_ECHOREPLY: return len == 8'd6;
         OPT_TIMESTAMP:           return len == 8'd10;
         default:                 return len >= 8'd2;
      endcase
   endfunction

   // One accepted byte: update the parse and say whether a record follows
   task automatic parse_step(input logic [7:0] b, input logic first,
                             output logic made, output rec_type rec);
      logic [3:0] off;
      int         slot;
      made = 1'b0;
      rec  = '0;
      if (first) begin
         clear_parser();
         phase = PH_HDR;
      end
      case (phase)
         PH_HDR: begin
            slot = seg_pos[4:2];
            if (slot < 5) hdr_word[slot] = {hdr_word[slot][23:0], b};
            seg_pos = seg_pos + 6'd1;
            if (seg_pos >= HDR_BYTES) begin
               off  = hdr_word[3][31:28];
               made = 1'b1;
               if (off < MIN_OFFSET) begin
                  phase = PH_DONE;
                  rec   = option_rec(REC_ERROR, '0, '0);
               end else begin
                  area_end             = {off, 2'b00};
                  rec.record_kind      = REC_HEADER;
                  rec.source_port      = hdr_word[0][31:16];
                  rec.destination_port = hdr_word[0][15:0];
                  rec.sequence_number  = hdr_word[1];
                  rec.ack_number       = hdr_word[2];
                  rec.data_offset      = off;
                  rec.flag_bits        = hdr_word[3][23:16];
                  rec.window_size      = hdr_word[3][15:0];
                  rec.checksum_field   = hdr_word[4][31:16];
                  rec.urgent_pointer   = hdr_word[4][15:0];
                  close_option();
               end
            end
         end
         PH_KIND: begin
            seg_pos = seg_pos + 6'd1;
            if (b <= 8'd1) begin
               close_option();
               made = 1'b1;
               rec  = option_rec((b == 8'd0) ? REC_END : REC_NOP, '0, '0);
            end else if (seg_pos >= area_end) begin
               // kind needs a length byte but the area ends here
               phase = PH_DONE;
               made  = 1'b1;
               rec   = option_rec(REC_ERROR, '0, '0);
            end else begin
               cur_kind = b;
               phase    = PH_LEN;
            end
         end
         PH_LEN: begin
            if (!legal_length(cur_kind, b) ||
                (int'(seg_pos) - 1 + int'(b) > int'(area_end))) begin
               phase = PH_DONE;
               made  = 1'b1;
               rec   = option_rec(REC_ERROR, '0, '0);
            end else begin
               seg_pos    = seg_pos + 6'd1;
               cur_len    = b;
               body_count = '0;
               body_acc   = '0;
               if (b == 8'd2) close_option();
               else phase = PH_BODY;
               if (b == 8'd2 && cur_kind == OPT_SACKOK) begin
                  made = 1'b1;
                  rec  = option_rec(REC_SACKOK, '0, '0);
               end else if (cur_kind >= OPT_FIRST_UNK) begin
                  made = 1'b1;
                  rec  = option_rec(REC_UNKNOWN, {24'd0, cur_kind}, {24'd0, b});
               end
            end
         end
         PH_BODY: begin
            seg_pos    = seg_pos + 6'd1;
            body_acc   = {body_acc[23:0], b};
            body_count = body_count + 8'd1;
            case (cur_kind)
               OPT_MSS: if (body_count == 8'd2) begin
                  made = 1'b1;
                  rec  = option_rec(REC_MSS, {16'd0, body_acc[15:0]}, '0);
               end
               OPT_WSCALE: if (body_count == 8'd1) begin
                  made = 1'b1;
                  rec  = option_rec(REC_WSCALE, {24'd0, b}, '0);
               end
               OPT_SACK: if (body_count[1:0] == 2'b00) begin
                  made = 1'b1;
                  rec  = option_rec(REC_SACK_WORD, body_acc, '0);
               end
               OPT_ECHO: if (body_count == 8'd4) begin
                  made = 1'b1;
                  rec  = option_rec(REC_ECHO, body_acc, '0);
               end
               OPT_ECHOREPLY: if (body_count == 8'd4) begin
                  made = 1'b1;
                  rec  = option_rec(REC_ECHOREPLY, body_acc, '0);
               end
               OPT_TIMESTAMP: begin
                  if (body_count == 8'd4) ts_hold = body_acc;
                  if (body_count == 8'd8) begin
                     made = 1'b1;
                     rec  = option_rec(REC_TIMESTAMP, ts_hold, body_acc);
                  end
               end
               default: ;
            endcase
            if (cur_len < 8'd2 || body_count >= cur_len - 8'd2) close_option();
         end
         default: ;  // idle, done and unused codes ignore the byte
      endcase
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // Result beats are checked before the byte of the same edge is predicted
   always @(posedge clock) begin
      logic    made;
      rec_type rec;
      rec_type want;
      if (reset) begin
         clear_parser();
         expected_records.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_records.size() == 0) begin
               mismatches++;
               $display("%0t ns: record expected none actual kind %0d", $time, rsp_tuser);
            end else begin
               want = expected_records.pop_front();
               compare_field("record_kind",      want.record_kind,      rsp_tuser);
               compare_field("source_port",      want.source_port,      rsp_tdata[15:0]);
               compare_field("destination_port", want.destination_port, rsp_tdata[31:16]);
               compare_field("sequence_number",  want.sequence_number,  rsp_tdata[63:32]);
               compare_field("ack_number",       want.ack_number,       rsp_tdata[95:64]);
               compare_field("data_offset",      want.data_offset,      rsp_tdata[99:96]);
               compare_field("flag_bits",        want.flag_bits,        rsp_tdata[107:100]);
               compare_field("window_size",      want.window_size,      rsp_tdata[123:108]);
               compare_field("checksum_field",   want.checksum_field,   rsp_tdata[139:124]);
               compare_field("urgent_pointer",   want.urgent_pointer,   rsp_tdata[155:140]);
               compare_field("option_value_a",   want.option_value_a,   rsp_tdata[187:156]);
               compare_field("option_value_b",   want.option_value_b,   rsp_tdata[219:188]);
               compare_field("tdata padding",    32'd0,                 rsp_tdata[223:220]);
            end
         end
         if (req_tvalid && req_tready) begin
            parse_step(req_tdata, req_tuser, made, rec);
            if (made) expected_records.push_back(rec);
         end
      end
      pending = expected_records.size();
   end

endmodule

### sim/tb_tcp_header_option_parser.sv
// Testbench top for the TCP header and option parser.
// Sends directed and random segments with random idling on both channels;
// tcphop_record_checker predicts and compares. Depends on tcphop_pkg.
`timescale 1ns / 100ps

module tb_tcp_header_option_parser;
   import tcphop_pkg::*;

   localparam logic [7:0] OPT_END_LIST = 8'd0;
   localparam logic [7:0] OPT_NOOP     = 8'd1;
   localparam int         RANDOM_BEATS = 450;
   localparam int         IDLE_LIMIT   = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'd0;   // [7:0] data_byte
   logic                  req_tuser  = 1'b0;   // [0] first_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] source_port ... [219:188] option_value_b, [223:220] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [3:0]            rsp_tuser;           // [3:0] record_kind
   int                    mismatches;
   int                    pending;

   logic [7:0] seg_bytes [$];
   bit         tx_burst = 1'b0;
   bit         rx_burst = 1'b0;
   int         useful_beats = 0;

   always #5 clock = ~clock;

   tcp_header_option_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tcphop_record_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // One byte beat, after a random gap unless in a burst
   task automatic send_beat(input logic [7:0] b, input logic first);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_segment(input int cut);
      for (int i = 0; i < cut; i++) send_beat(seg_bytes[i], i == 0);
   endtask

   task automatic push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) seg_bytes.push_back(w[8*i +: 8]);
   endtask

   // Directed header: every byte the same fill, offset nibble in byte 12
   task automatic push_header(input logic [3:0] off, input logic [7:0] fill);
      for (int i = 0; i < 20; i++) seg_bytes.push_back((i == 12) ? {off, fill[3:0]} : fill);
   endtask

   // n bytes from a right-aligned vector, most significant first
   task automatic push_vec(input logic [319:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) seg_bytes.push_back(v[8*i +: 8]);
   endtask

   // Random segment: mostly well-formed options, some corrupted
   task automatic build_random_segment(output int useful);
      logic [3:0]  off;
      logic [31:0] w3;
      int          area, room, pick, n, k;
      seg_bytes.delete();
      if ($urandom_range(0, 15) == 0) off = 4'($urandom_range(0, 4));
      else if ($urandom_range(0, 3) == 0) off = 4'd15;
      else off = 4'($urandom_range(5, 15));
      w3 = $urandom;
      w3[31:28] = off;
      push_word($urandom);
      push_word($urandom);
      push_word($urandom);
      push_word(w3);
      push_word($urandom);
      area = (off >= 5) ? (int'(off) - 5) * 4 : 0;
      room = area;
      while (room > 0) begin
         pick = $urandom_range(0, 9);
         n = 0;
         case (pick)
            2: if (room >= 4) begin
               push_vec({OPT_MSS, 8'd4}, 2);
               repeat (2) seg_bytes.push_back(8'($urandom));
               n = 4;
            end
            3: if (room >= 3) begin
               push_vec({OPT_WSCALE, 8'd3}, 2);
               seg_bytes.push_back(8'($urandom));
               n = 3;
            end
            4: if (room >= 2) begin
               push_vec({OPT_SACKOK, 8'd2}, 2);
               n = 2;
            end
            5: if (room >= 2) begin
               k = $urandom_range(0, ((room - 2) / 4 > 4) ? 4 : (room - 2) / 4);
               n = 2 + 4 * k;
               push_vec({OPT_SACK, 8'(n)}, 2);
               repeat (4 * k) seg_bytes.push_back(8'($urandom));
            end
            6, 7: if (room >= 6) begin
               push_vec({(pick == 6) ? OPT_ECHO : OPT_ECHOREPLY, 8'd6}, 2);
               repeat (4) seg_bytes.push_back(8'($urandom));
               n = 6;
            end
            8: if (room >= 10) begin
               push_vec({OPT_TIMESTAMP, 8'd10}, 2);
               repeat (8) seg_bytes.push_back(8'($urandom));
               n = 10;
            end
            9: if (room >= 2) begin
               n = $urandom_range(2, (room < 12) ? room : 12);
               seg_bytes.push_back(8'($urandom_range(9, 255)));
               seg_bytes.push_back(8'(n));
               repeat (n - 2) seg_bytes.push_back(8'($urandom));
            end
            default: ;
         endcase
         if (n == 0) begin
            seg_bytes.push_back($urandom_range(0, 1) ? OPT_NOOP : OPT_END_LIST);
            n = 1;
         end
         room -= n;
      end
      // corruption: stray byte, kind on the last byte, or a length overrun
      if (area > 0 && $urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 2))
            0: seg_bytes[20 + $urandom_range(0, area - 1)] = 8'($urandom);
            1: seg_bytes[19 + area] = 8'($urandom_range(2, 255));
            default: if (area >= 2) begin
               seg_bytes[18 + area] = 8'($urandom_range(9, 255));
               seg_bytes[19 + area] = 8'($urandom_range(3, 40));
            end
         endcase
      end
      repeat ($urandom_range(0, 4)) seg_bytes.push_back(8'($urandom));
      useful = 20 + area;
   endtask

   // Result side: random stall before each beat, with burst stretches
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Watchdog on cycles with no beat on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb_tcp_header_option_parser NOT OK");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int useful, cut;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // bytes before any first byte
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);

      // all-ones header, full option area with every known option but echo reply
      seg_bytes.delete();
      push_header(4'd15, 8'hFF);
      push_vec(152'h0204FFFF_0303FF_0402_050A00000000FFFFFFFF, 19);
      push_vec(168'h080AFFFFFFFF00000001_060680000000_FF02_010000, 21);
      push_vec(16'hA55A, 2);
      send_segment(seg_bytes.size());

      // all-zero header with minimum offset, then payload
      seg_bytes.delete();
      push_header(4'd5, 8'h00);
      push_vec(16'h0102, 2);
      send_segment(seg_bytes.size());

      // offset below five, trailing byte dropped
      seg_bytes.delete();
      push_header(4'd4, 8'h00);
      push_vec(8'h02, 1);
      send_segment(seg_bytes.size());

      // echo reply, then SACK with no words
      seg_bytes.delete();
      push_header(4'd7, 8'($urandom));
      push_vec(64'h07061234_56780502, 8);
      send_segment(seg_bytes.size());

      // unknown kind with skipped body
      seg_bytes.delete();
      push_header(4'd6, 8'($urandom));
      push_vec(32'h0904ABCD, 4);
      send_segment(seg_bytes.size());

      // bad MSS length
      seg_bytes.delete();
      push_header(4'd6, 8'($urandom));
      push_vec(32'h02030000, 4);
      send_segment(seg_bytes.size());

      // kind on the last byte of the area
      seg_bytes.delete();
      push_header(4'd6, 8'($urandom));
      push_vec(32'h01010102, 4);
      send_segment(seg_bytes.size());

      // length runs past the area
      seg_bytes.delete();
      push_header(4'd6, 8'($urandom));
      push_vec(32'h0A050000, 4);
      send_segment(seg_bytes.size());

      // unknown kind with length below two
      seg_bytes.delete();
      push_header(4'd6, 8'($urandom));
      push_vec(32'h09010000, 4);
      send_segment(seg_bytes.size());

      // restart in the middle of a header
      seg_bytes.delete();
      push_header(4'd8, 8'($urandom));
      send_segment(10);
      seg_bytes.delete();
      push_header(4'd5, 8'hFF);
      send_segment(seg_bytes.size());

      // random segments, some cut short by the next first byte
      while (useful_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
         build_random_segment(useful);
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seg_bytes.size())
                                           : seg_bytes.size();
         send_segment(cut);
         useful_beats += (cut < useful) ? cut : useful;
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0);
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the longest result stall to expose extra records
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_tcp_header_option_parser OK");
      end else begin
         $display("tb_tcp_header_option_parser NOT OK");
      end
      $finish;
   end

endmodule

### files.f
sv/tcphop_pkg.sv
sv/tcphop_parse.sv
sv/tcphop_out.sv
sv/tcp_header_option_parser.sv
sim/tcphop_record_checker.sv
sim/tb_tcp_header_option_parser.sv
